/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* hw/rtl/imhq_pkg.sv */
// package for the indexed min-heap queue
package imhq_pkg;
    localparam int HeapDepth = 256;
    localparam int ItemCount = 256;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_UPDATE  = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_MARK,
        S_DECIDE,
        S_EXT_LAST,
        S_EXT_MOVE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_DONE
    } state_t;
endpackage

/* hw/rtl/indexed_min_heap_queue.sv */
// Indexed min-heap priority queue. Pulse start while busy is low with command,
// item_id and cost; the result appears for one cycle with done high and
// cannot be stalled, so the receiver must take it then. Every command first
// reads the position map and its mark, then decides; query and rejected
// commands go on to done. Insert sifts up from the new last slot; extract
// takes the root, moves the last entry there and sifts down; update sifts
// its entry up or down by how the new cost compares with the old. Each sift
// level reads the heap memory, compares and writes back one slot. With 256
// entries a sift passes through at most 8 levels. Only one operation is
// in flight at a time.
`include "assert_macros.svh"
module indexed_min_heap_queue #(
    parameter int HEAP_DEPTH = imhq_pkg::HeapDepth,
    parameter int ITEM_COUNT = imhq_pkg::ItemCount
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [7:0]         item_id,
    input  logic signed [31:0] cost,
    output logic               done,
    output logic [1:0]         status,
    output logic [7:0]         out_item,
    output logic signed [31:0] out_cost,
    output logic [7:0]         heap_position,
    output logic               present
);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int IA = $clog2(ITEM_COUNT);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    imhq_pkg::state_t state_reg, state_next;

    logic [1:0]         cmd_reg;
    logic [7:0]         id_reg;
    logic signed [31:0] cost_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [7:0]         ei_reg, ei_next;          // entry being sifted
    logic signed [31:0] ec_reg, ec_next;
    logic [7:0]         ci_reg, ci_next;          // left child held
    logic signed [31:0] cc_reg, cc_next;
    logic [1:0]         st_reg, st_next;
    logic [7:0]         oi_reg, oi_next;
    logic signed [31:0] oc_reg, oc_next;
    logic [7:0]         op_reg, op_next;
    logic               pr_reg, pr_next;
    logic               qhit_reg, qhit_next;      // query cost comes from the slot read

    // memory ports
    logic               h_we;
    logic [AW-1:0]      h_waddr, h_raddr;
    logic [7:0]         h_witem, h_ritem;
    logic signed [31:0] h_wcost, h_rcost;
    logic               p_we, m_set, m_clr;
    logic [IA-1:0]      p_waddr, m_addr, p_raddr;
    logic [AW-1:0]      p_wpos, p_rpos;
    logic               p_rmark;

    imhq_heap_mem #(.DEPTH(HEAP_DEPTH), .IW(8)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_waddr), .witem(h_witem), .wcost(h_wcost),
        .raddr(h_raddr), .ritem(h_ritem), .rcost(h_rcost)
    );

    imhq_pos_mem #(.ITEMS(ITEM_COUNT), .PW(AW)) u_pos (
        .clk(clk), .rst_n(rst_n), .we(p_we), .waddr(p_waddr), .wpos(p_wpos),
        .mark_set(m_set), .mark_clr(m_clr), .mark_addr(m_addr),
        .raddr(p_raddr), .rpos(p_rpos), .rmark(p_rmark)
    );

    logic          id_valid;
    logic [CW-1:0] left_ext, right_ext;
    logic [AW-1:0] parent_a;

    assign id_valid  = 32'(id_reg) < ITEM_COUNT;
    assign left_ext  = CW'({pos_reg, 1'b1});
    assign right_ext = left_ext + CW'(1);
    assign parent_a  = AW'((pos_reg - AW'(1)) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imhq_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == imhq_pkg::S_IDLE && start)
        begin
            cmd_reg  <= command;
            id_reg   <= item_id;
            cost_reg <= cost;
        end
        pos_reg  <= pos_next;
        ei_reg   <= ei_next;
        ec_reg   <= ec_next;
        ci_reg   <= ci_next;
        cc_reg   <= cc_next;
        st_reg   <= st_next;
        oi_reg   <= oi_next;
        oc_reg   <= oc_next;
        op_reg   <= op_next;
        pr_reg   <= pr_next;
        qhit_reg <= qhit_next;
    end

    logic          use_right;
    logic          dn_swap;
    logic [AW-1:0] pick_a;
    logic [7:0]    pick_i;
    logic signed [31:0] pick_c;

    // in DN_CMP: cc holds left child, h_r* holds right child if present
    always_comb
    begin
        use_right = (right_ext < cnt_reg) && (cc_reg > h_rcost);
        pick_a    = use_right ? AW'(right_ext) : AW'(left_ext);
        pick_i    = use_right ? h_ritem : ci_reg;
        pick_c    = use_right ? h_rcost : cc_reg;
        dn_swap   = pick_c < ec_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imhq_pkg::S_IDLE:
                if (start) state_next = imhq_pkg::S_RD_MARK;
            imhq_pkg::S_RD_MARK:
                state_next = imhq_pkg::S_DECIDE;
            imhq_pkg::S_DECIDE:
            begin
                state_next = imhq_pkg::S_DONE;
                case (imhq_pkg::cmd_t'(cmd_reg))
                    imhq_pkg::CMD_INSERT:
                        if (id_valid && !p_rmark && 32'(cnt_reg) < HEAP_DEPTH)
                            state_next = imhq_pkg::S_UP_RD;
                    imhq_pkg::CMD_EXTRACT:
                        if (cnt_reg != '0) state_next = imhq_pkg::S_EXT_LAST;
                    imhq_pkg::CMD_UPDATE:
                        if (id_valid && p_rmark && CW'(p_rpos) < cnt_reg)
                            state_next = imhq_pkg::S_EXT_MOVE;
                    default: ;
                endcase
            end
            imhq_pkg::S_EXT_LAST:
                state_next = imhq_pkg::S_EXT_MOVE;
            imhq_pkg::S_EXT_MOVE:
                if (cmd_reg == imhq_pkg::CMD_UPDATE)
                    state_next = (h_rcost < cost_reg) ? imhq_pkg::S_DN_RD
                                                      : imhq_pkg::S_UP_RD;
                else
                    state_next = (cnt_reg == '0) ? imhq_pkg::S_DONE
                                                 : imhq_pkg::S_DN_RD;
            imhq_pkg::S_UP_RD:
                state_next = (pos_reg == '0) ? imhq_pkg::S_DONE : imhq_pkg::S_UP_CMP;
            imhq_pkg::S_UP_CMP:
                state_next = (ec_reg < h_rcost) ? imhq_pkg::S_UP_RD : imhq_pkg::S_DONE;
            imhq_pkg::S_DN_RD:
                state_next = (left_ext >= cnt_reg) ? imhq_pkg::S_DONE
                                                   : imhq_pkg::S_DN_RD2;
            imhq_pkg::S_DN_RD2:
                state_next = imhq_pkg::S_DN_CMP;
            imhq_pkg::S_DN_CMP:
                state_next = dn_swap ? imhq_pkg::S_DN_RD : imhq_pkg::S_DONE;
            imhq_pkg::S_DONE:
                state_next = imhq_pkg::S_IDLE;
            default:
                state_next = imhq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        ei_next   = ei_reg;
        ec_next   = ec_reg;
        ci_next   = ci_reg;
        cc_next   = cc_reg;
        st_next   = st_reg;
        oi_next   = oi_reg;
        oc_next   = oc_reg;
        op_next   = op_reg;
        pr_next   = pr_reg;
        qhit_next = qhit_reg;
        h_we      = 1'b0;
        h_waddr   = pos_reg;
        h_witem   = ei_reg;
        h_wcost   = ec_reg;
        h_raddr   = '0;
        p_we      = 1'b0;
        p_waddr   = IA'(ei_reg);
        p_wpos    = pos_reg;
        m_set     = 1'b0;
        m_clr     = 1'b0;
        m_addr    = IA'(id_reg);
        p_raddr   = IA'(item_id);
        case (state_reg)
            imhq_pkg::S_IDLE:
            begin
                p_raddr = IA'(item_id);
                h_raddr = '0;
            end
            imhq_pkg::S_RD_MARK:
            begin
                p_raddr = IA'(id_reg);
                h_raddr = '0;
            end
            imhq_pkg::S_DECIDE:
            begin
                st_next   = imhq_pkg::ST_OK;
                oi_next   = id_reg;
                oc_next   = '0;
                op_next   = '0;
                pr_next   = 1'b0;
                qhit_next = 1'b0;
                ei_next   = id_reg;
                ec_next   = cost_reg;
                case (imhq_pkg::cmd_t'(cmd_reg))
                    imhq_pkg::CMD_INSERT:
                        if (!id_valid || p_rmark)
                        begin
                            st_next = imhq_pkg::ST_INVALID;
                            pr_next = id_valid && p_rmark;
                        end
                        else if (32'(cnt_reg) >= HEAP_DEPTH)
                            st_next = imhq_pkg::ST_FULL;
                        else
                        begin
                            oc_next  = cost_reg;
                            pr_next  = 1'b1;
                            pos_next = AW'(cnt_reg);
                            cnt_next = cnt_reg + CW'(1);
                            m_set    = 1'b1;
                        end
                    imhq_pkg::CMD_EXTRACT:
                        if (cnt_reg == '0)
                        begin
                            st_next = imhq_pkg::ST_EMPTY;
                            oi_next = '0;
                        end
                        else
                        begin
                            oi_next  = h_ritem;
                            oc_next  = h_rcost;
                            m_clr    = 1'b1;
                            m_addr   = IA'(h_ritem);
                            cnt_next = cnt_reg - CW'(1);
                            h_raddr  = AW'(cnt_reg - CW'(1));
                        end
                    imhq_pkg::CMD_UPDATE:
                        if (!id_valid || !p_rmark || CW'(p_rpos) >= cnt_reg)
                            st_next = imhq_pkg::ST_INVALID;
                        else
                        begin
                            oc_next  = cost_reg;
                            pr_next  = 1'b1;
                            pos_next = p_rpos;
                            h_raddr  = p_rpos;
                        end
                    default:
                        if (!id_valid)
                            st_next = imhq_pkg::ST_INVALID;
                        else if (p_rmark)
                        begin
                            pr_next = 1'b1;
                            if (CW'(p_rpos) < cnt_reg)
                            begin
                                op_next   = 8'(p_rpos);
                                pos_next  = p_rpos;
                                h_raddr   = p_rpos;
                                qhit_next = 1'b1;
                            end
                        end
                endcase
            end
            imhq_pkg::S_EXT_LAST:
            begin
                h_raddr = AW'(cnt_reg);
            end
            imhq_pkg::S_EXT_MOVE:
            begin
                if (cmd_reg == imhq_pkg::CMD_EXTRACT)
                begin
                    ei_next  = h_ritem;
                    ec_next  = h_rcost;
                    pos_next = '0;
                end
            end
            imhq_pkg::S_UP_RD:
            begin
                h_raddr = parent_a;
                h_we    = 1'b1;
                p_we    = 1'b1;
                if (pos_reg == '0) op_next = 8'(pos_reg);
            end
            imhq_pkg::S_UP_CMP:
            begin
                if (ec_reg < h_rcost)
                begin
                    // move parent down into this slot
                    h_we     = 1'b1;
                    h_witem  = h_ritem;
                    h_wcost  = h_rcost;
                    p_we     = 1'b1;
                    p_waddr  = IA'(h_ritem);
                    pos_next = parent_a;
                end
                else
                    op_next = 8'(pos_reg);
            end
            imhq_pkg::S_DN_RD:
            begin
                h_we    = 1'b1;
                p_we    = 1'b1;
                h_raddr = AW'(left_ext);
                if (left_ext >= cnt_reg) op_next = (cmd_reg == imhq_pkg::CMD_UPDATE)
                                                   ? 8'(pos_reg) : op_reg;
            end
            imhq_pkg::S_DN_RD2:
            begin
                ci_next = h_ritem;
                cc_next = h_rcost;
                h_raddr = AW'(right_ext);
            end
            imhq_pkg::S_DN_CMP:
            begin
                if (dn_swap)
                begin
                    h_we     = 1'b1;
                    h_witem  = pick_i;
                    h_wcost  = pick_c;
                    p_we     = 1'b1;
                    p_waddr  = IA'(pick_i);
                    pos_next = pick_a;
                end
                else
                    op_next = (cmd_reg == imhq_pkg::CMD_UPDATE) ? 8'(pos_reg) : op_reg;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = state_reg != imhq_pkg::S_IDLE;
        done          = state_reg == imhq_pkg::S_DONE;
        status        = st_reg;
        out_item      = oi_reg;
        out_cost      = qhit_reg ? h_rcost : oc_reg;
        heap_position = op_reg;
        present       = pr_reg;
    end

    `ASSERT_IMPLIES(a_done_busy, clk, rst_n, done, busy)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_cnt_range, clk, rst_n, 1'b1, 32'(cnt_reg) <= HEAP_DEPTH)
    `ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy)
endmodule

/* hw/rtl/imhq_heap_mem.sv */
// heap slot memory holding item and cost per slot
module imhq_heap_mem #(
    parameter int DEPTH = imhq_pkg::HeapDepth,
    parameter int IW    = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [IW-1:0]            witem,
    input  logic signed [31:0]       wcost,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [IW-1:0]            ritem,
    output logic signed [31:0]       rcost
);
    logic [IW+31:0] mem [DEPTH];
    logic [IW+31:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {witem, wcost};
        end
        rd_reg <= mem[raddr];
    end

    assign ritem = rd_reg[IW+31:32];
    assign rcost = rd_reg[31:0];
endmodule

/* hw/rtl/imhq_pos_mem.sv */
// position map memory with in-heap marks
module imhq_pos_mem #(
    parameter int ITEMS = imhq_pkg::ItemCount,
    parameter int PW    = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(ITEMS)-1:0] waddr,
    input  logic [PW-1:0]            wpos,
    input  logic                     mark_set,
    input  logic                     mark_clr,
    input  logic [$clog2(ITEMS)-1:0] mark_addr,
    input  logic [$clog2(ITEMS)-1:0] raddr,
    output logic [PW-1:0]            rpos,
    output logic                     rmark
);
    logic [PW-1:0]    mem [ITEMS];
    logic [PW-1:0]    rd_reg;
    logic [ITEMS-1:0] marks_reg;
    logic             mark_rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wpos;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg   <= '0;
            mark_rd_reg <= 1'b0;
        end
        else
        begin
            if (mark_set)
            begin
                marks_reg[mark_addr] <= 1'b1;
            end
            else if (mark_clr)
            begin
                marks_reg[mark_addr] <= 1'b0;
            end
            mark_rd_reg <= marks_reg[raddr];
        end
    end

    assign rpos  = rd_reg;
    assign rmark = mark_rd_reg;
endmodule
